[src/tgp_pkg.sv]
// Turtle plotter package: modes, widths, constants and the sine function.
// Used by every module of the plotter; no dependencies.
`default_nettype none
package tgp_pkg;
	localparam int MaxSide = 256;
	localparam int AddrW = 16;
	localparam int SineEntries = 256;
	localparam int SineBits = 8;
	localparam logic signed [23:0] PosMax = 24'sh7FFFFF;
	localparam logic signed [23:0] PosMin = -24'sh800000;

	typedef enum logic [3:0] {
		MODE_HEADING = 4'd0, MODE_SET_X = 4'd1, MODE_SET_Y = 4'd2, MODE_FORWARD = 4'd3,
		MODE_TURN = 4'd4, MODE_PEN_UP = 4'd5, MODE_PEN_DOWN = 4'd6, MODE_COLOR = 4'd7,
		MODE_READ = 4'd8
	} mode_t;

	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_STEP = 2'd2;

	// command from controller to datapath
	typedef struct packed {
		logic load;      // latch request
		logic setup_a;   // execute command, start step divider
		logic setup_b;   // scale increments
		logic step;      // one walk step
		logic plot;      // write current point
		logic clr;       // clear-pass write
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic walk_zero;  // no steps to make
		logic same;       // last step left position unchanged
		logic last;       // no steps left
	} dp_stat_t;

	// Quantized Q1.15 sine over a 16-bit angle (constant table logic).
	function automatic logic signed [16:0] sine_q15(input logic [15:0] a);
		logic [15:0] p;
		logic [1:0] quad;
		logic [63:0] x, x2, t, s;
		p = {a[15:16-SineBits], {(16 - SineBits){1'b0}}};
		quad = p[15:14];
		x = {50'd0, p[13:0]};
		if (quad[0]) x = 64'd16384 - x;
		x2 = (x * x) >> 14;
		t = 64'd83564 - ((x2 * 64'd4909) >> 14);
		t = 64'd677343 - ((x2 * t) >> 14);
		t = 64'd1647099 - ((x2 * t) >> 14);
		s = (x * t) >> 14;
		s = (s + 64'd16) >> 5;
		if (s > 64'd32767) s = 64'd32767;
		return quad[1] ? -$signed({2'b00, s[14:0]}) : $signed({2'b00, s[14:0]});
	endfunction
endpackage
`default_nettype wire

[src/tgp_table.sv]
// Sine lookup: table of SineEntries quantized Q1.15 values, registered output.
// Depends on tgp_pkg.
`default_nettype none
module tgp_table
	import tgp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic [SineBits-1:0]   idx,
	output logic signed [16:0]         val_q
);
	logic signed [16:0] rom [SineEntries];
	always_comb begin
		for (int i = 0; i < SineEntries; i++)
			rom[i] = sine_q15(16'(i << (16 - SineBits)));
	end
	always_ff @(posedge clk) begin
		val_q <= rom[idx];
	end
endmodule
`default_nettype wire

[src/tgp_datapath.sv]
// Plotter datapath: turtle state, step divider, increments, frame store.
// Depends on tgp_pkg and tgp_table.
`default_nettype none
module tgp_datapath
	import tgp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_idx,
	input  wire logic [23:0]        cfg_data,
	input  wire logic [3:0]         mode,
	input  wire logic signed [31:0] operand,
	input  wire logic [7:0]         pixel_x,
	input  wire logic [7:0]         pixel_y,
	input  wire logic [AddrW-1:0]   clr_addr,
	input  wire dp_cmd_t            cmd,
	output dp_stat_t                stat,
	output logic [7:0]              pix_q,
	output logic                    pen_q,
	output logic signed [23:0]      x_q,
	output logic signed [23:0]      y_q
);
	logic [8:0] w_q, h_q;
	logic [23:0] step_q;
	logic [15:0] heading_q;
	logic [7:0] color_q;
	logic [3:0] mode_q;
	logic signed [31:0] op_q;
	logic [7:0] px_q, py_q;
	logic [39:0] rem_q;
	logic [39:0] quo_q;
	logic [5:0] div_cnt_q;
	logic div_busy_q;
	logic [39:0] n_q;
	logic signed [23:0] dx_q, dy_q;
	logic sel_q;
	logic same_q;
	logic plot_pend_q;
	logic signed [16:0] tab_val;
	logic [7:0] mem [MaxSide*MaxSide];

	// degrees to binary angle, floor((op+180)/360): floor by 8 as a shift, then
	// floor by 45 as a reciprocal multiply on a value biased by 45 * 2^23, which
	// keeps it nonnegative and leaves the low 16 quotient bits unchanged
	logic signed [33:0] deg_sum;
	logic signed [30:0] deg_u;
	logic [29:0] deg_w;
	logic [60:0] deg_prod;
	logic [15:0] ang;
	assign deg_sum = 34'(op_q) + 34'sd180;
	assign deg_u = deg_sum[33:3];
	assign deg_w = 30'(deg_u + 31'sd377487360);
	assign deg_prod = 61'(deg_w) * 61'd1527099484;
	assign ang = deg_prod[51:36];

	function automatic logic signed [23:0] sat(input logic signed [32:0] v);
		if (v > 33'(PosMax)) return PosMax;
		if (v < 33'(PosMin)) return PosMin;
		return v[23:0];
	endfunction

	logic signed [32:0] nx, ny;
	assign nx = 33'(x_q) + 33'(dx_q);
	assign ny = 33'(y_q) + 33'(dy_q);

	// pixel address
	logic [8:0] we_w, we_h;
	logic signed [33:0] colp, rowp;
	logic signed [17:0] col, row;
	logic on_canvas;
	assign we_w = (w_q > 9'(MaxSide)) ? 9'(MaxSide) : w_q;
	assign we_h = (h_q > 9'(MaxSide)) ? 9'(MaxSide) : h_q;
	assign colp = 34'(x_q) * $signed({25'd0, we_w});
	assign rowp = 34'(y_q) * $signed({25'd0, we_h});
	assign col = colp[33:16];
	assign row = rowp[33:16];
	assign on_canvas = !col[17] && !row[17] && (col < $signed({9'd0, we_w}))
		&& (row < $signed({9'd0, we_h}));

	// table output is registered from its index: sine is looked up while scaling
	tgp_table u_tab (
		.clk(clk),
		.idx(cmd.setup_b ? heading_q[15:16-SineBits]
			: 8'(heading_q[15:16-SineBits] + 8'd64)),
		.val_q(tab_val)
	);

	logic signed [41:0] prod;
	logic signed [41:0] rnd;
	assign prod = 42'(tab_val) * $signed({18'd0, step_q});
	assign rnd = (prod + 42'sd4194304) >>> 23;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= 9'd256; h_q <= 9'd256; step_q <= 24'd32768;
			x_q <= 24'sd32768; y_q <= 24'sd32768; heading_q <= 16'd49152;
			pen_q <= 1'b1; color_q <= 8'd255; div_busy_q <= 1'b0; sel_q <= 1'b0;
			plot_pend_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_WIDTH: w_q <= cfg_data[8:0];
					REG_HEIGHT: h_q <= cfg_data[8:0];
					REG_STEP: step_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				mode_q <= mode; op_q <= operand; px_q <= pixel_x; py_q <= pixel_y;
				same_q <= 1'b0;
			end
			if (cmd.setup_a) begin
				// execute simple modes; start division for forward
				unique case (mode_q)
					MODE_HEADING: heading_q <= ang;
					MODE_SET_X: x_q <= sat(33'(op_q));
					MODE_SET_Y: y_q <= sat(33'(op_q));
					MODE_TURN: heading_q <= heading_q + ang;
					MODE_PEN_UP: pen_q <= 1'b0;
					MODE_PEN_DOWN: pen_q <= 1'b1;
					MODE_COLOR: color_q <= op_q[7:0];
					default: ;
				endcase
				rem_q <= 40'd0;
				quo_q <= {op_q, 8'd0} + 40'(step_q) - 40'd1;
				div_cnt_q <= 6'd40;
				div_busy_q <= (mode_q == MODE_FORWARD);
				sel_q <= 1'b0;
			end else if (div_busy_q) begin
				// restoring divider, one quotient bit a cycle
				logic [40:0] r;
				r = {rem_q, quo_q[39]};
				if (r >= 41'(step_q)) begin
					rem_q <= 40'(r - 41'(step_q)); quo_q <= {quo_q[38:0], 1'b1};
				end else begin
					rem_q <= r[39:0]; quo_q <= {quo_q[38:0], 1'b0};
				end
				div_cnt_q <= div_cnt_q - 6'd1;
				if (div_cnt_q == 6'd1) div_busy_q <= 1'b0;
			end
			if (cmd.setup_b) begin
				// first use: cosine already registered; then sine
				if (!sel_q) begin dx_q <= rnd[23:0]; sel_q <= 1'b1; n_q <= quo_q; end
				else dy_q <= rnd[23:0];
			end
			if (cmd.step) begin
				x_q <= sat(nx); y_q <= sat(ny);
				same_q <= (sat(nx) == x_q) && (sat(ny) == y_q);
				n_q <= n_q - 40'd1;
			end
			// a walk step plots its new point on the following cycle
			plot_pend_q <= cmd.step && pen_q;
		end
	end

	assign stat.div_done = !div_busy_q;
	assign stat.walk_zero = (n_q == 40'd0) || op_q[31] || (op_q == 32'sd0) || (step_q == 24'd0);
	assign stat.same = same_q;
	assign stat.last = (n_q == 40'd0);

	always_ff @(posedge clk) begin
		if (cmd.clr) mem[clr_addr] <= 8'd0;
		else if ((cmd.plot || plot_pend_q) && on_canvas) mem[{row[7:0], col[7:0]}] <= color_q;
		pix_q <= mem[{py_q, px_q}];
	end
endmodule
`default_nettype wire

[src/tgp_ctrl.sv]
// Plotter controller: clear pass, command sequencing, forward walk, result.
// Depends on tgp_pkg.
`default_nettype none
module tgp_ctrl
	import tgp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire logic [3:0]       mode,
	output logic [AddrW-1:0]      clr_addr,
	output dp_cmd_t               cmd,
	input  wire dp_stat_t         stat,
	output logic                  rd_sel
);
	typedef enum logic [2:0] {S_CLR, S_IDLE, S_EXEC, S_DIV, S_SIN, S_COS, S_WALK, S_DONE}
		state_t;
	state_t state_q;
	logic [3:0] mode_q;
	logic [AddrW-1:0] clr_q;
	logic done_fire;

	assign clr_addr = clr_q;
	assign in_ready = (state_q == S_IDLE) && !out_valid;
	// read stays in S_DONE until rd_sel is up, for the registered store data
	assign done_fire = (state_q == S_DONE) && !((mode_q == MODE_READ) && !rd_sel);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.setup_a = (state_q == S_EXEC);
		cmd.setup_b = (state_q == S_SIN) || (state_q == S_COS);
		cmd.clr = (state_q == S_CLR);
		cmd.step = (state_q == S_WALK) && !stat.last && !stat.same;
		cmd.plot = (state_q == S_DONE) && (mode_q == MODE_PEN_DOWN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR; clr_q <= '0; out_valid <= 1'b0; mode_q <= MODE_HEADING;
			rd_sel <= 1'b0;
		end else begin
			rd_sel <= (state_q == S_DONE) && (mode_q == MODE_READ) && !rd_sel;
			if (done_fire) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {AddrW{1'b1}}) state_q <= S_IDLE;
				end
				S_IDLE: if (cmd.load) begin mode_q <= mode; state_q <= S_EXEC; end
				S_EXEC: state_q <= (mode_q == MODE_FORWARD) ? S_DIV : S_DONE;
				S_DIV: if (stat.div_done) state_q <= S_SIN;
				S_SIN: state_q <= S_COS;
				S_COS: state_q <= stat.walk_zero ? S_DONE : S_WALK;
				S_WALK: if (stat.last || stat.same) state_q <= S_DONE;
				S_DONE: if (done_fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
	a_clr_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !out_valid) else $error("result during clear");
`endif
endmodule
`default_nettype wire

[src/turtle_graphics_plotter_core.sv]
// Turtle graphics plotter core: one command request in, one result out.
// s_axis_tdata {pixel_y, pixel_x, operand, mode}; m_axis_tdata {pos_y, pos_x, pen, pixel}.
// Configuration by cfg_we/cfg_idx/cfg_data while idle.
// After arst_n the 64K-entry frame store is cleared, one byte a cycle, and
// s_axis_tready stays low during the clear.
// Simple commands pass through S_EXEC and S_DONE before m_axis_tvalid rises; a read
// also waits in S_DONE for the registered store data. Forward: setup in S_EXEC,
// the serial step-count divider in S_DIV, the increments in S_SIN and S_COS, the
// walk in S_WALK at one step per cycle (skipped when no step is made), then S_DONE.
// One request at a time; the result sits in the output register until taken,
// and no new request is accepted while it waits or during a walk.
// Depends on tgp_pkg, tgp_ctrl, tgp_datapath, tgp_table.
`default_nettype none
module turtle_graphics_plotter_core
	import tgp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [55:0] s_axis_tdata,  // mode[3:0], operand[35:4], pixel_x[43:36], pixel_y[51:44]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // pixel_value[7:0], pen_is_down[8], x[32:9], y[56:33]
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [23:0] cfg_data
);
	dp_cmd_t cmd;
	dp_stat_t stat;
	logic [AddrW-1:0] clr_addr;
	logic rd_sel;
	logic [7:0] pix;
	logic pen;
	logic signed [23:0] px, py;
	logic [7:0] pix_out_q;

	tgp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .mode(s_axis_tdata[3:0]),
		.clr_addr(clr_addr), .cmd(cmd), .stat(stat), .rd_sel(rd_sel)
	);

	tgp_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.mode(s_axis_tdata[3:0]), .operand(s_axis_tdata[35:4]),
		.pixel_x(s_axis_tdata[43:36]), .pixel_y(s_axis_tdata[51:44]),
		.clr_addr(clr_addr), .cmd(cmd), .stat(stat),
		.pix_q(pix), .pen_q(pen), .x_q(px), .y_q(py)
	);

	// read data is valid the cycle rd_sel is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pix_out_q <= 8'd0;
		else if (cmd.load) pix_out_q <= 8'd0;
		else if (rd_sel) pix_out_q <= pix;
	end

	assign m_axis_tdata = {7'd0, py, px, pen, pix_out_q};
endmodule
`default_nettype wire

[tb/turtle_graphics_plotter_core_test.sv]
// Testbench for turtle_graphics_plotter_core: a directed table, then random command streams
// over several canvas and step settings, results checked against literal rows or a local turtle model.
// Depends on tgp_pkg and the core RTL.
`timescale 1ns / 1ps
module turtle_graphics_plotter_core_test;
	import tgp_pkg::*;

	typedef struct packed {
		logic [7:0]  pix;
		logic        pen;
		logic [23:0] x;
		logic [23:0] y;
	} result_t;

	typedef struct {
		logic [3:0]  mode;
		logic [31:0] op;
		logic [7:0]  px;
		logic [7:0]  py;
		bit          typed;
		result_t     res;
	} cmd_row_t;

	logic        clk, arst_n;
	logic        s_axis_tvalid, s_axis_tready;
	logic [55:0] s_axis_tdata;
	logic        m_axis_tvalid, m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [23:0] cfg_data;

	turtle_graphics_plotter_core dut (.*);

	// turtle model state
	longint      tur_x, tur_y;
	logic [15:0] tur_heading;
	bit          tur_pen;
	logic [7:0]  tur_color;
	logic [7:0]  canvas [65536];
	logic [8:0]  cv_w, cv_h;
	logic [23:0] cv_step;

	result_t     pending_results[$];
	int          errors = 0;
	int          n_requests = 0;
	int          n_settings = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic longint floor_div(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) q--;
		return q;
	endfunction

	function automatic longint clamp_pos(longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	function automatic longint quarter_sine(logic [15:0] ang);
		logic [15:0] p;
		logic [63:0] x, x2, t, s;
		p = {ang[15:8], 8'd0};
		x = {50'd0, p[13:0]};
		if (p[14]) x = 64'd16384 - x;
		x2 = (x * x) >> 14;
		t = 64'd83564 - ((x2 * 64'd4909) >> 14);
		t = 64'd677343 - ((x2 * t) >> 14);
		t = 64'd1647099 - ((x2 * t) >> 14);
		s = (x * t) >> 14;
		s = (s + 64'd16) >> 5;
		if (s > 64'd32767) s = 64'd32767;
		return p[15] ? -longint'(s) : longint'(s);
	endfunction

	function automatic void mark_point();
		longint w, h, c, r;
		w = (cv_w > 256) ? 256 : cv_w;
		h = (cv_h > 256) ? 256 : cv_h;
		c = floor_div(tur_x * w, 65536);
		r = floor_div(tur_y * h, 65536);
		if (c >= 0 && r >= 0 && c < w && r < h) canvas[r * 256 + c] = tur_color;
	endfunction

	function automatic logic [15:0] deg_to_angle(longint op);
		return 16'(floor_div(op + 180, 360));
	endfunction

	function automatic void walk(longint distance);
		longint n, k, c, s, dx, dy, nx, ny;
		bit same;
		if (distance <= 0 || cv_step == 0) return;
		n = ((distance << 8) + cv_step - 1) / cv_step;
		c = quarter_sine(tur_heading + 16'd16384);
		s = quarter_sine(tur_heading);
		dx = floor_div(c * cv_step + 4194304, 8388608);
		dy = floor_div(s * cv_step + 4194304, 8388608);
		for (k = 0; k < n; k++) begin
			nx = clamp_pos(tur_x + dx);
			ny = clamp_pos(tur_y + dy);
			same = (nx == tur_x) && (ny == tur_y);
			tur_x = nx;
			tur_y = ny;
			if (tur_pen) mark_point();
			if (same) break;
		end
	endfunction

	function automatic result_t turtle_predict(logic [3:0] mode, logic [31:0] op_bits,
			logic [7:0] px, logic [7:0] py);
		result_t r;
		longint op;
		op = longint'($signed(op_bits));
		r.pix = 8'd0;
		case (mode)
			MODE_HEADING:  tur_heading = deg_to_angle(op);
			MODE_SET_X:    tur_x = clamp_pos(op);
			MODE_SET_Y:    tur_y = clamp_pos(op);
			MODE_FORWARD:  walk(op);
			MODE_TURN:     tur_heading = tur_heading + deg_to_angle(op);
			MODE_PEN_UP:   tur_pen = 0;
			MODE_PEN_DOWN: begin
				tur_pen = 1;
				mark_point();
			end
			MODE_COLOR:    tur_color = op_bits[7:0];
			MODE_READ:     r.pix = canvas[{py, px}];
			default: ;
		endcase
		r.pen = tur_pen;
		r.x = 24'(tur_x);
		r.y = 24'(tur_y);
		return r;
	endfunction

	// one request; typed rows queue their literal result, the model still advances
	task automatic send_cmd(logic [3:0] mode, logic [31:0] op, logic [7:0] px, logic [7:0] py,
			bit typed, result_t lit);
		int gap;
		result_t r;
		gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, py, px, op, mode};
		do @(posedge clk); while (!s_axis_tready);
		r = turtle_predict(mode, op, px, py);
		pending_results.push_back(typed ? lit : r);
		n_requests++;
	endtask

	task automatic write_settings(logic [8:0] w, logic [8:0] h, logic [23:0] stp);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= REG_WIDTH;
		cfg_data <= {15'd0, w};
		@(posedge clk);
		cfg_idx <= REG_HEIGHT;
		cfg_data <= {15'd0, h};
		@(posedge clk);
		cfg_idx <= REG_STEP;
		cfg_data <= stp;
		@(posedge clk);
		cfg_we <= 1'b0;
		cv_w = w;
		cv_h = h;
		cv_step = stp;
		n_settings++;
	endtask

	task automatic random_cmd();
		int sel;
		logic [3:0] mode;
		logic [31:0] op;
		longint d;
		sel = $urandom_range(0, 99);
		op = $urandom;
		if (sel < 25) begin
			mode = MODE_FORWARD;
			if ($urandom_range(0, 9) == 0) begin
				// long runs only where steps are coarse enough to saturate fast
				if (cv_step < 24'h100000) op = -$urandom_range(0, 1000);
			end else begin
				d = (longint'($urandom_range(0, 200)) * cv_step) >> 8;
				op = 32'(d + $urandom_range(0, 3));
			end
		end else if (sel < 45) begin
			mode = sel < 35 ? MODE_HEADING : MODE_TURN;
			if (sel[0]) op = $urandom_range(0, 360) << 16;
		end else if (sel < 60) begin
			mode = sel < 52 ? MODE_SET_X : MODE_SET_Y;
			if (sel[1:0] != 0) op = $urandom_range(0, 65535);
		end else if (sel < 70) begin
			mode = sel < 64 ? MODE_PEN_UP : MODE_PEN_DOWN;
		end else if (sel < 75) begin
			mode = MODE_COLOR;
		end else if (sel < 95) begin
			mode = MODE_READ;
		end else begin
			mode = 4'($urandom_range(9, 15));
		end
		send_cmd(mode, op, 8'($urandom), 8'($urandom), 1'b0, '0);
	endtask

	// result checker
	always @(posedge clk) begin
		result_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[32:9], m_axis_tdata[56:33]};
			if (pending_results.size() == 0) begin
				$error("unexpected result %h", got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.pix !== want.pix) begin
					$error("pixel_value exp %0d got %0d", want.pix, got.pix);
					errors++;
				end
				if (got.pen !== want.pen) begin
					$error("pen_is_down exp %0d got %0d", want.pen, got.pen);
					errors++;
				end
				if (got.x !== want.x) begin
					$error("position_x exp %h got %h", want.x, got.x);
					errors++;
				end
				if (got.y !== want.y) begin
					$error("position_y exp %h got %h", want.y, got.y);
					errors++;
				end
			end
		end
	end

	// result side backpressure
	initial begin
		int gap;
		m_axis_tready <= 1'b0;
		forever begin
			gap = $urandom_range(0, 2) == 0 ? $urandom_range(1, 6) : 0;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	localparam result_t HOME = '{8'd0, 1'b1, 24'h008000, 24'h008000};

	cmd_row_t directed [] = '{
		'{MODE_READ,     32'd0,          8'd0,   8'd0,   1, HOME},
		'{MODE_PEN_DOWN, 32'd0,          8'd0,   8'd0,   1, HOME},
		'{MODE_READ,     32'd0,          8'd128, 8'd128, 1, '{8'd255, 1'b1, 24'h008000, 24'h008000}},
		'{4'd9,          32'hFFFFFFFF,   8'd255, 8'd255, 1, HOME},
		'{4'd15,         32'h0,          8'd0,   8'd0,   1, HOME},
		'{MODE_SET_X,    32'h7FFFFFFF,   8'd0,   8'd0,   1, '{8'd0, 1'b1, 24'h7FFFFF, 24'h008000}},
		'{MODE_SET_X,    32'h80000000,   8'd0,   8'd0,   1, '{8'd0, 1'b1, 24'h800000, 24'h008000}},
		'{MODE_SET_Y,    32'hFFFFFFFF,   8'd0,   8'd0,   0, '0},
		'{MODE_SET_X,    32'd16384,      8'd0,   8'd0,   0, '0},
		'{MODE_HEADING,  32'd0,          8'd0,   8'd0,   0, '0},
		'{MODE_FORWARD,  32'd0,          8'd0,   8'd0,   0, '0},
		'{MODE_FORWARD,  32'hFFFFFFFB,   8'd0,   8'd0,   0, '0},
		'{MODE_FORWARD,  32'd65536,      8'd0,   8'd0,   0, '0},
		'{MODE_COLOR,    32'h00012345,   8'd0,   8'd0,   0, '0},
		'{MODE_PEN_UP,   32'd0,          8'd0,   8'd0,   0, '0},
		'{MODE_TURN,     32'd90 << 16,   8'd0,   8'd0,   0, '0},
		'{MODE_FORWARD,  32'h7FFFFFFF,   8'd0,   8'd0,   0, '0},
		'{MODE_PEN_DOWN, 32'd0,          8'd0,   8'd0,   0, '0},
		'{MODE_TURN,     -(32'd45 << 16), 8'd0,  8'd0,   0, '0},
		'{MODE_SET_Y,    32'd30000,      8'd0,   8'd0,   0, '0},
		'{MODE_FORWARD,  32'd40000,      8'd0,   8'd0,   0, '0},
		'{MODE_READ,     32'd0,          8'd255, 8'd255, 0, '0},
		'{MODE_HEADING,  32'h80000000,   8'd0,   8'd0,   0, '0},
		'{MODE_FORWARD,  32'd20000,      8'd0,   8'd0,   0, '0}
	};

	initial begin
		logic [8:0] ws [6] = '{9'd256, 9'd1, 9'd511, 9'd0, 9'd100, 9'd256};
		logic [8:0] hs [6] = '{9'd256, 9'd1, 9'd511, 9'd37, 9'd200, 9'd256};
		logic [23:0] steps [6] = '{24'd32768, 24'd1, 24'hFFFFFF, 24'd4096, 24'd0, 24'd32768};
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_WIDTH;
		cfg_data <= '0;
		tur_x = 32768;
		tur_y = 32768;
		tur_heading = 16'd49152;
		tur_pen = 1;
		tur_color = 8'd255;
		cv_w = 256;
		cv_h = 256;
		cv_step = 32768;
		foreach (canvas[i]) canvas[i] = 8'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_cmd(directed[i].mode, directed[i].op, directed[i].px, directed[i].py,
				directed[i].typed, directed[i].res);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5)
				write_settings(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)),
					24'($urandom_range(2048, 200000)));
			else
				write_settings(ws[ph], hs[ph], steps[ph]);
			repeat (191) random_cmd();
		end

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Checked %0d requests over %0d canvas/step settings", n_requests, n_settings);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

[filelist.f]
src/tgp_pkg.sv
src/tgp_table.sv
src/tgp_datapath.sv
src/tgp_ctrl.sv
src/turtle_graphics_plotter_core.sv
tb/turtle_graphics_plotter_core_test.sv
